FILE: design/float32_to_lowbit_float_top_assert.svh
// Assertion macros for the float32 to low-bit float converter.
`ifndef FLOAT32_TO_LOWBIT_FLOAT_TOP_ASSERT_SVH
`define FLOAT32_TO_LOWBIT_FLOAT_TOP_ASSERT_SVH

// Check that a condition implies a consequence on the same edge.
`define F2L_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define F2L_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/f2l_pkg.sv
`timescale 1ns / 1ps
package f2l_pkg;

  localparam int unsigned FmtCount = 6;
  localparam int unsigned PipeDepth = 3;

  localparam logic [2:0] FMT_E5M2 = 3'd0;
  localparam logic [2:0] FMT_E4M3 = 3'd1;
  localparam logic [2:0] FMT_E3M2 = 3'd2;
  localparam logic [2:0] FMT_E2M3 = 3'd3;
  localparam logic [2:0] FMT_E3M0 = 3'd4;
  localparam logic [2:0] FMT_E2M1 = 3'd5;

  typedef struct packed {
    logic [2:0] exp_w;
    logic [1:0] man_w;
    logic [4:0] max_exp;
    logic [2:0] max_man;
    logic [3:0] bias;
  } fmt_info_t;

  function automatic fmt_info_t fmt_info(input logic [2:0] sel);
    fmt_info_t f;
    case (sel)
      FMT_E4M3: f = '{3'd4, 2'd3, 5'd15, 3'd6, 4'd7};
      FMT_E3M2: f = '{3'd3, 2'd2, 5'd7, 3'd3, 4'd3};
      FMT_E2M3: f = '{3'd2, 2'd3, 5'd3, 3'd7, 4'd1};
      FMT_E3M0: f = '{3'd3, 2'd0, 5'd7, 3'd0, 4'd3};
      FMT_E2M1: f = '{3'd2, 2'd1, 5'd3, 3'd1, 4'd1};
      default:  f = '{3'd5, 2'd2, 5'd30, 3'd3, 4'd15};
    endcase
    return f;
  endfunction

  // Stage 1 to stage 2: decoded input.
  typedef struct packed {
    logic        sign;
    logic [2:0]  sel;
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic        normal;     // target exponent at least one
    logic [5:0]  sh;         // right shift of the 24-bit significand
    logic [8:0]  ne;         // target exponent before rounding (normal path)
    logic [23:0] sig;
  } dec_t;

  // Stage 2 to stage 3: rounded value.
  typedef struct packed {
    logic        sign;
    logic [2:0]  sel;
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic [8:0]  ex;
    logic [2:0]  man;
    logic        unf;
  } rnd_t;

endpackage

FILE: design/f2l_decode.sv
`timescale 1ns / 1ps
module f2l_decode import f2l_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vld_i,
  input  logic [31:0] bits_i,
  input  logic [2:0]  sel_i,
  output logic        vld_o,
  output dec_t        dec_o
);
  fmt_info_t f;
  dec_t      d_d, dec_q;
  logic      vld_q;
  logic [9:0] ne_s;
  logic [9:0] sub_sh;

  always_comb begin
    f         = fmt_info(sel_i);
    d_d       = '0;
    d_d.sign  = bits_i[31];
    d_d.sel   = sel_i;
    d_d.is_nan  = (bits_i[30:23] == 8'hFF) && (bits_i[22:0] != '0);
    d_d.is_inf  = (bits_i[30:23] == 8'hFF) && (bits_i[22:0] == '0);
    d_d.is_zero = (bits_i[30:23] == 8'h00);
    d_d.sig   = {1'b1, bits_i[22:0]};
    ne_s      = {2'b00, bits_i[30:23]} - 10'd127 + {6'd0, f.bias};
    d_d.normal = !ne_s[9] && (ne_s != '0);
    d_d.ne    = ne_s[8:0];
    // subnormal shift: 23 - M + 1 - ne, saturated at 32
    sub_sh    = 10'd24 - {8'd0, f.man_w} - ne_s;
    if (d_d.normal)
      d_d.sh = 6'd23 - {4'd0, f.man_w};
    else if (sub_sh > 10'd32)
      d_d.sh = 6'd32;
    else
      d_d.sh = sub_sh[5:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else         vld_q <= vld_i;
  end
  always_ff @(posedge clk_i) begin
    dec_q <= d_d;
  end
  assign vld_o = vld_q;
  assign dec_o = dec_q;
endmodule

FILE: design/f2l_round.sv
`timescale 1ns / 1ps
module f2l_round import f2l_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  vld_i,
  input  dec_t  dec_i,
  output logic  vld_o,
  output rnd_t  rnd_o
);
  fmt_info_t   f;
  rnd_t        r_d, rnd_q;
  logic        vld_q;
  logic [24:0] rs;
  logic [24:0] one_m;

  always_comb begin
    f    = fmt_info(dec_i.sel);
    // round half up: shift, then add the last bit shifted out
    if (dec_i.sh >= 6'd32) rs = '0;
    else rs = ({1'b0, dec_i.sig} >> dec_i.sh) +
              (({1'b0, dec_i.sig} >> (dec_i.sh - 6'd1)) & 25'd1);
    one_m = 25'd1 << f.man_w;
    r_d         = '0;
    r_d.sign    = dec_i.sign;
    r_d.sel     = dec_i.sel;
    r_d.is_nan  = dec_i.is_nan;
    r_d.is_inf  = dec_i.is_inf;
    r_d.is_zero = dec_i.is_zero;
    if (dec_i.normal) begin
      if (rs >= (one_m << 1)) begin
        r_d.ex  = dec_i.ne + 9'd1;
        r_d.man = 3'(((rs >> 1) - one_m));
      end else begin
        r_d.ex  = dec_i.ne;
        r_d.man = 3'(rs - one_m);
      end
    end else begin
      if (rs >= one_m) begin
        r_d.ex  = 9'd1;
        r_d.man = 3'(rs - one_m);
      end else begin
        r_d.ex  = 9'd0;
        r_d.man = 3'(rs);
        r_d.unf = (rs == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else         vld_q <= vld_i;
  end
  always_ff @(posedge clk_i) begin
    rnd_q <= r_d;
  end
  assign vld_o = vld_q;
  assign rnd_o = rnd_q;
endmodule

FILE: design/f2l_pack.sv
`timescale 1ns / 1ps
module f2l_pack import f2l_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       vld_i,
  input  rnd_t       rnd_i,
  output logic       vld_o,
  output logic [7:0] code_o,
  output logic       ovf_o,
  output logic       unf_o,
  output logic       nan_o
);
  fmt_info_t  f;
  logic [4:0] ex;
  logic [2:0] man;
  logic       sat, ovf, unf, nan;
  logic [7:0] code_d, code_q;
  logic       vld_q, ovf_q, unf_q, nan_q;

  always_comb begin
    f   = fmt_info(rnd_i.sel);
    ex  = '0;
    man = '0;
    sat = 1'b0;
    unf = 1'b0;
    nan = 1'b0;
    if (rnd_i.is_nan) begin
      if (rnd_i.sel == FMT_E5M2) begin
        ex = 5'd31; man = 3'd1;
      end else if (rnd_i.sel == FMT_E4M3) begin
        ex = 5'd15; man = 3'd7;
      end else begin
        nan = 1'b1;
      end
    end else if (rnd_i.is_inf) begin
      sat = 1'b1;
    end else if (!rnd_i.is_zero) begin
      ex  = rnd_i.ex[4:0];
      man = rnd_i.man;
      unf = rnd_i.unf;
      if (rnd_i.ex > {4'd0, f.max_exp}) sat = 1'b1;
      else if (rnd_i.sel == FMT_E4M3 && rnd_i.ex == 9'd15 && rnd_i.man == 3'd7)
        sat = 1'b1;
    end
    ovf = sat;
    if (sat) begin
      if (rnd_i.sel == FMT_E5M2) begin
        ex = 5'd31; man = 3'd0;
      end else begin
        ex = f.max_exp; man = f.max_man;
      end
    end
    code_d = 8'(({8'd0, rnd_i.sign} << (f.exp_w + 3'(f.man_w))) |
                ({4'd0, ex} << f.man_w) | {6'd0, man});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else         vld_q <= vld_i;
  end
  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    ovf_q  <= ovf;
    unf_q  <= unf;
    nan_q  <= nan;
  end
  assign vld_o  = vld_q;
  assign code_o = code_q;
  assign ovf_o  = ovf_q;
  assign unf_o  = unf_q;
  assign nan_o  = nan_q;
endmodule

FILE: design/float32_to_lowbit_float_top.sv
`timescale 1ns / 1ps
// float32 to low-bit float converter.
// Request channel: drive float_bits_i with start high for one cycle; the
// request is taken at that edge, since busy is always low (no internal
// back-pressure). A new request may follow on every cycle.
// Result channel: the request passes the decode, round and pack registers;
// done_o then marks each result for exactly one cycle, together with code_o
// and the overflow, underflow and nan_unrepresentable flags. Results leave
// in request order.
// Throughput: one request per cycle, set by the three-stage pipeline
// (decode and shift select, round, saturate and pack).
// Configuration: fmt_we_i with fmt_data_i writes the format selector
// (0 E5M2, 1 E4M3, 2 E3M2, 3 E2M3, 4 E3M0, 5 E2M1); codes 6 and 7 are
// dropped and the old value held. Write only while no request is in flight.
// Reset clears the pipeline valid bits and selects E5M2.
// The receiver cannot stall: each result is shown for one cycle only.
module float32_to_lowbit_float_top import f2l_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] float_bits_i,
  input  logic        fmt_we_i,
  input  logic [2:0]  fmt_data_i,
  output logic        done_o,
  output logic [7:0]  code_o,
  output logic        overflow_o,
  output logic        underflow_o,
  output logic        nan_unrepresentable_o
);
  logic [2:0] sel_q;
  logic       v1, v2;
  dec_t       dec;
  rnd_t       rnd;

  // hold the selector; drop unused codes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= FMT_E5M2;
    end else if (fmt_we_i && (32'(fmt_data_i) < FmtCount)) begin
      sel_q <= fmt_data_i;
    end
  end

  assign busy = 1'b0;

  f2l_decode u_dec (
    .clk_i(clk_i), .rst_ni(rst_ni), .vld_i(start && !busy),
    .bits_i(float_bits_i), .sel_i(sel_q), .vld_o(v1), .dec_o(dec)
  );
  f2l_round u_rnd (
    .clk_i(clk_i), .rst_ni(rst_ni), .vld_i(v1), .dec_i(dec),
    .vld_o(v2), .rnd_o(rnd)
  );
  f2l_pack u_pack (
    .clk_i(clk_i), .rst_ni(rst_ni), .vld_i(v2), .rnd_i(rnd),
    .vld_o(done_o), .code_o(code_o), .ovf_o(overflow_o),
    .unf_o(underflow_o), .nan_o(nan_unrepresentable_o)
  );

`include "float32_to_lowbit_float_top_assert.svh"
  `F2L_ASSERT_NEXT(a_adv, clk_i, rst_ni, v1, v2, "stage valid lost")
  `F2L_ASSERT_IMP(a_sel, clk_i, rst_ni, 1'b1, 32'(sel_q) < FmtCount, "bad format")
  `F2L_ASSERT_IMP(a_flags, clk_i, rst_ni, done_o, !(overflow_o && underflow_o), "flag clash")

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import f2l_pkg::*;

  typedef struct {
    logic [7:0] code;
    logic       ovf;
    logic       unf;
    logic       nanerr;
  } conv_res_t;

  localparam int unsigned IdleLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] float_bits_i = '0;
  logic        fmt_we_i = 1'b0;
  logic [2:0]  fmt_data_i = '0;
  logic        done_o;
  logic [7:0]  code_o;
  logic        overflow_o;
  logic        underflow_o;
  logic        nan_unrepresentable_o;

  logic [31:0] pending_q[$];
  int unsigned gap_q[$];
  conv_res_t   expected_q[$];
  logic [2:0]  fmt_sel = FMT_E5M2;
  int unsigned err_count = 0;
  int unsigned req_count = 0;
  int unsigned res_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left = 0;
  bit          drive_en = 1'b0;

  float32_to_lowbit_float_top u_top (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .float_bits_i,
    .fmt_we_i,
    .fmt_data_i,
    .done_o,
    .code_o,
    .overflow_o,
    .underflow_o,
    .nan_unrepresentable_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Round half up on the magnitude after a right shift of at least one.
  function automatic logic [31:0] shift_round(input logic [31:0] v, input int unsigned sh);
    if (sh >= 32) return '0;
    return (v >> sh) + ((v >> (sh - 1)) & 32'd1);
  endfunction

  // Work out the low-bit code and flags for one float32 pattern.
  function automatic conv_res_t convert_float(input logic [31:0] x, input logic [2:0] sel);
    int          ew, mw, maxe, maxm, bias, ne;
    logic        sgn;
    logic [7:0]  fe;
    logic [22:0] fm;
    logic [31:0] sig, ex, man;
    bit          sat;
    conv_res_t   r;
    case (sel)
      FMT_E4M3: begin ew = 4; mw = 3; maxe = 15; maxm = 6; end
      FMT_E3M2: begin ew = 3; mw = 2; maxe = 7;  maxm = 3; end
      FMT_E2M3: begin ew = 2; mw = 3; maxe = 3;  maxm = 7; end
      FMT_E3M0: begin ew = 3; mw = 0; maxe = 7;  maxm = 0; end
      FMT_E2M1: begin ew = 2; mw = 1; maxe = 3;  maxm = 1; end
      default:  begin ew = 5; mw = 2; maxe = 30; maxm = 3; end
    endcase
    sgn = x[31];
    fe = x[30:23];
    fm = x[22:0];
    ex = 0;
    man = 0;
    sat = 0;
    r = '{default: '0};
    if (fe == 8'hFF) begin
      if (fm == 0) sat = 1;
      else if (sel == FMT_E5M2) begin ex = 31; man = 1; end
      else if (sel == FMT_E4M3) begin ex = 15; man = 7; end
      else r.nanerr = 1'b1;
    end else if (fe != 0) begin
      bias = (1 << (ew - 1)) - 1;
      ne = int'(fe) - 127 + bias;
      sig = {9'd1, fm};
      if (ne >= 1) begin
        sig = shift_round(sig, 23 - mw);
        if (sig >= (32'd1 << (mw + 1))) begin
          sig = sig >> 1;
          ne++;
        end
        man = sig - (32'd1 << mw);
        ex = ne;
      end else begin
        man = shift_round(sig, 24 - mw - ne);
        if (man >= (32'd1 << mw)) begin
          man -= (32'd1 << mw);
          ex = 1;
        end
        if (ex == 0 && man == 0) r.unf = 1'b1;
      end
      if (ex > maxe) sat = 1;
      else if (sel == FMT_E4M3 && ex == 15 && man == 7) sat = 1;
    end
    if (sat) begin
      r.ovf = 1'b1;
      if (sel == FMT_E5M2) begin ex = 31; man = 0; end
      else begin ex = maxe; man = maxm; end
    end
    r.code = 8'((32'(sgn) << (ew + mw)) | (ex << mw) | man);
    return r;
  endfunction

  function automatic logic [31:0] rand_float();
    logic [31:0] x;
    x = $urandom;
    // Bias the exponent towards the interesting band around each format's range.
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: x[30:23] = 8'($urandom_range(100, 145));
      6: x[30:23] = 8'hFF;
      7: x[30:23] = 8'h00;
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) x[19:0] = $urandom_range(0, 1) ? '0 : '1;
    return x;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  // Driver: present the head request, hold it until accepted, then draw a gap.
  always @(negedge clk_i) begin
    if (drive_en && gap_left == 0 && pending_q.size() > 0) begin
      start <= 1'b1;
      float_bits_i <= pending_q[0];
    end else begin
      start <= 1'b0;
      float_bits_i <= $urandom;
      if (gap_left > 0) gap_left--;
    end
  end

  // Monitor: record accepted requests, check results, run the watchdog.
  always @(posedge clk_i) begin
    conv_res_t want;
    if (rst_ni) begin
      if (start && !busy) begin
        expected_q.push_back(convert_float(float_bits_i, fmt_sel));
        void'(pending_q.pop_front());
        gap_left = gap_q.pop_front();
        req_count++;
      end
      if (done_o) begin
        res_count++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", code_o, 0);
        end else begin
          want = expected_q.pop_front();
          if (code_o !== want.code) report_mismatch("code", code_o, want.code);
          if (overflow_o !== want.ovf) report_mismatch("overflow", overflow_o, want.ovf);
          if (underflow_o !== want.unf) report_mismatch("underflow", underflow_o, want.unf);
          if (nan_unrepresentable_o !== want.nanerr)
            report_mismatch("nan_unrepresentable", nan_unrepresentable_o, want.nanerr);
        end
      end
      if ((start && !busy) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no traffic for %0d cycles", IdleLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic add_request(input logic [31:0] x, input bit gaps);
    pending_q.push_back(x);
    gap_q.push_back(gaps ? $urandom_range(0, 15) : 0);
  endtask

  // Drain the pipeline, then write the selector at a falling edge.
  task automatic write_format(input logic [2:0] val);
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (PipeDepth + 2) @(negedge clk_i);
    drive_en = 1'b0;
    fmt_we_i <= 1'b1;
    fmt_data_i <= val;
    @(negedge clk_i);
    fmt_we_i <= 1'b0;
    if (val < FmtCount) fmt_sel = val;
    drive_en = 1'b1;
  endtask

  initial begin
    logic [31:0] directed[$];
    logic [2:0]  plan[$];
    bit          gaps;
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
                 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFF80_0001,
                 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0080_0000, 32'h3F80_0000,
                 32'hBFC0_0000, 32'h43E0_0000, 32'h43F0_0000, 32'h4770_0000,
                 32'h477F_FFFF, 32'h3B00_0000, 32'h3A80_0000, 32'h3C00_0000,
                 32'h4080_0000, 32'h40C0_0000, 32'h3E80_0000, 32'h3F40_0000};
    // Every format, the unused selectors (which must be dropped), both extremes.
    plan = '{FMT_E5M2, FMT_E4M3, FMT_E3M2, 3'd6, FMT_E2M3, FMT_E3M0, 3'd7, FMT_E2M1,
             FMT_E4M3, FMT_E5M2};
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    drive_en = 1'b1;
    foreach (plan[p]) begin
      write_format(plan[p]);
      foreach (directed[i]) add_request(directed[i], 1'b0);
      // Alternate back-to-back bursts with randomly gapped stretches.
      for (int i = 0; i < 42; i++) begin
        gaps = (i / 14) % 2;
        add_request(rand_float(), gaps);
      end
    end
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (PipeDepth + 5) @(posedge clk_i);
    $display("covered %0d requests and %0d results over all six formats", req_count,
             res_count);
    $display("directed zeros, subnormals, infinities, NaNs and range edges, then random");
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
